// File: rtl/nps_pkg.sv
package nps_pkg;

   localparam int COORD_W = 20;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int LEN_W   = 42;
   localparam int DOT_W   = 43;
   localparam int NUM_W   = 58;
   localparam int T_W     = 35;
   localparam int ERR_W   = 25;
   localparam int DIST_W  = 52;
   localparam int EXC_W   = 29;
   localparam int CNT_W   = 7;
   localparam int SEG_W   = 6;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic REG_POINT_COUNT = 1'b0;

   typedef struct packed {
      logic                       kind;
      logic [5:0]                 point_index;
      logic signed [COORD_W-1:0]  coord_x;
      logic signed [COORD_W-1:0]  coord_y;
      logic signed [COORD_W-1:0]  coord_z;
   } req_item_type;

   typedef struct packed {
      logic [SEG_W-1:0] segment_index;
      logic             any_accepted;
   } rsp_item_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] z;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } point_type;

   typedef struct packed {
      logic signed [DIFF_W-1:0] z;
      logic signed [DIFF_W-1:0] y;
      logic signed [DIFF_W-1:0] x;
   } diff_type;

   typedef struct packed {
      logic done;
      logic rem_nonzero;
   } div_status_type;

   function automatic logic signed [COORD_W-1:0] point_coord(point_type p, logic [1:0] c);
      case (c)
         2'd0:    return p.x;
         2'd1:    return p.y;
         default: return p.z;
      endcase
   endfunction

   function automatic logic signed [DIFF_W-1:0] diff_coord(diff_type d, logic [1:0] c);
      case (c)
         2'd0:    return d.x;
         2'd1:    return d.y;
         default: return d.z;
      endcase
   endfunction

endpackage

// File: rtl/nearest_polyline_segment.sv
// Channel      Ports                               Transaction
// request      start, busy, req_item               one load or query item
// response     rsp_valid, rsp_item                 one result per query, one cycle
// config       psel, penable, pwrite, paddr, ...   point_count register write/read
//
// A load takes effect at the accept edge; busy stays low and no result follows.
// A query first fetches its first point, then per segment loads the far point; a segment is
// dropped by the zero-length or window test or after the square-root check, or is accepted and
// waits on the 58-step serial divider before projection; DONE follows the last segment.
// Points come from one synchronous point memory, read one point per segment.
// Reset clears control state and sets point_count to 2; the point memory is not cleared.
// The receiver cannot stall: rsp_valid is a one-cycle strobe, in the cycle busy drops.
module nearest_polyline_segment #(
   parameter int MAX_POINTS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  nps_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   output nps_pkg::rsp_item_type rsp_item,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [2:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);
   import nps_pkg::*;

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int NW = $clog2(MAX_POINTS + 1) + 1;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_LOADA   = 4'd1;
   localparam logic [3:0] S_LOADB   = 4'd2;
   localparam logic [3:0] S_ACC     = 4'd3;
   localparam logic [3:0] S_TEST    = 4'd4;
   localparam logic [3:0] S_SQ      = 4'd5;
   localparam logic [3:0] S_SQCMP   = 4'd6;
   localparam logic [3:0] S_DIVGO   = 4'd7;
   localparam logic [3:0] S_DIVWAIT = 4'd8;
   localparam logic [3:0] S_PROJ    = 4'd9;
   localparam logic [3:0] S_CMP     = 4'd10;
   localparam logic [3:0] S_NEXT    = 4'd11;
   localparam logic [3:0] S_DONE    = 4'd12;

   // point memory
   logic [$bits(point_type)-1:0] mem [MAX_POINTS];
   logic [$bits(point_type)-1:0] rdata_ff;
   logic [AW-1:0]                rd_addr;
   logic                         wr_en;

   logic [3:0]               state_ff, state_in;
   logic [CNT_W-1:0]         count_ff;
   logic [NW-1:0]            n_ff, n_in;
   logic [NW-1:0]            seg_ff, seg_in;
   logic [1:0]               c_ff, c_in;
   point_type                q_ff, q_in;
   point_type                a_ff, a_in;
   point_type                b_ff, b_in;
   point_type                rd_point;
   diff_type                 dv_ff, dv_in;
   diff_type                 w_ff, w_in;
   logic [LEN_W-1:0]         len_ff, len_in;
   logic signed [DOT_W-1:0]  dot_ff, dot_in;
   logic [EXC_W-1:0]         exc_ff, exc_in;
   logic [NUM_W-1:0]         sq_ff, sq_in;
   logic signed [T_W-1:0]    t_ff, t_in;
   logic signed [ERR_W-1:0]  e_ff, e_in;
   logic [DIST_W-1:0]        dist_ff, dist_in;
   logic [DIST_W-1:0]        best_ff, best_in;
   logic [SEG_W-1:0]         best_idx_ff, best_idx_in;
   logic                     any_ff, any_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // arithmetic
   logic signed [DIFF_W-1:0]     dv_c, w_c;
   logic signed [COORD_W-1:0]    a_c, q_c;
   logic signed [2*DIFF_W-1:0]   dd_prod, wd_prod;
   logic signed [DOT_W+1:0]      exc;
   logic [DOT_W-1:0]             dot_mag;
   logic [NUM_W-1:0]             div_num;
   logic [NUM_W-1:0]             div_quot;
   div_status_type               div_status;
   logic [T_W:0]                 t_mag;
   logic [T_W:0]                 t_wide;
   logic signed [DIFF_W+T_W-1:0] proj_prod;
   logic signed [ERR_W+15:0]     e_wide;
   logic signed [2*ERR_W-1:0]    e_sq;
   logic [NW-1:0]                n_clamp;
   logic                         cfg_write;

   assign rd_point = point_type'(rdata_ff);
   assign busy     = state_ff != S_IDLE;
   assign wr_en    = start && !busy && req_item.kind == KIND_LOAD
                     && (32'(req_item.point_index) < MAX_POINTS);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[AW'(req_item.point_index)] <= {req_item.coord_z, req_item.coord_y,
                                            req_item.coord_x};
      end
      rdata_ff <= mem[rd_addr];
   end

   // config port
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == REG_POINT_COUNT) ? {25'd0, count_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CNT_W'(2);
      end else if (cfg_write && paddr[2] == REG_POINT_COUNT) begin
         count_ff <= pwdata[CNT_W-1:0];
      end
   end

   assign n_clamp = (32'(count_ff) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(count_ff);

   assign dv_c = diff_coord(dv_ff, c_ff);
   assign w_c  = diff_coord(w_ff, c_ff);
   assign a_c  = point_coord(a_ff, c_ff);
   assign q_c  = point_coord(q_ff, c_ff);

   assign dd_prod = dv_c * dv_c;
   assign wd_prod = w_c * dv_c;
   assign exc     = dot_ff - $signed({3'b000, len_ff}) - (DOT_W+2)'(65536);
   assign dot_mag = dot_ff[DOT_W-1] ? DOT_W'(-dot_ff) : DOT_W'(dot_ff);
   assign div_num = {dot_mag[NUM_W-17:0], 16'd0};

   // floor of the signed quotient from the magnitude quotient and remainder
   assign t_mag  = div_quot[T_W:0] + (T_W+1)'(div_status.rem_nonzero && dot_ff[DOT_W-1]);
   assign t_wide = dot_ff[DOT_W-1] ? (T_W+1)'(-t_mag) : t_mag;

   assign proj_prod = dv_c * t_ff;
   assign e_wide    = $signed(proj_prod[DIFF_W+T_W-1:16]) + a_c - q_c;
   assign e_sq      = e_ff * e_ff;

   nps_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (state_ff == S_DIVGO),
      .num    (div_num),
      .den    (len_ff),
      .quot   (div_quot),
      .status (div_status)
   );

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      seg_in       = seg_ff;
      c_in         = c_ff;
      q_in         = q_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      dv_in        = dv_ff;
      w_in         = w_ff;
      len_in       = len_ff;
      dot_in       = dot_ff;
      exc_in       = exc_ff;
      sq_in        = sq_ff;
      t_in         = t_ff;
      e_in         = e_ff;
      dist_in      = dist_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      any_in       = any_ff;
      rsp_valid_in = 1'b0;
      rd_addr      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start && req_item.kind == KIND_QUERY) begin
               q_in        = {req_item.coord_z, req_item.coord_y, req_item.coord_x};
               n_in        = n_clamp;
               seg_in      = '0;
               any_in      = 1'b0;
               best_idx_in = '0;
               best_in     = '0;
               state_in    = (n_clamp < NW'(2)) ? S_DONE : S_LOADA;
            end
         end
         S_LOADA: begin
            // hold the first point, fetch the second
            a_in     = rd_point;
            rd_addr  = AW'(1);
            state_in = S_LOADB;
         end
         S_LOADB: begin
            b_in     = rd_point;
            dv_in.x  = DIFF_W'(rd_point.x) - DIFF_W'(a_ff.x);
            dv_in.y  = DIFF_W'(rd_point.y) - DIFF_W'(a_ff.y);
            dv_in.z  = DIFF_W'(rd_point.z) - DIFF_W'(a_ff.z);
            w_in.x   = DIFF_W'(q_ff.x) - DIFF_W'(a_ff.x);
            w_in.y   = DIFF_W'(q_ff.y) - DIFF_W'(a_ff.y);
            w_in.z   = DIFF_W'(q_ff.z) - DIFF_W'(a_ff.z);
            len_in   = '0;
            dot_in   = '0;
            c_in     = '0;
            state_in = S_ACC;
         end
         S_ACC: begin
            len_in = len_ff + LEN_W'($unsigned(dd_prod));
            dot_in = dot_ff + DOT_W'(wd_prod);
            c_in   = c_ff + 2'd1;
            if (c_ff == 2'd2) begin
               state_in = S_TEST;
            end
         end
         S_TEST: begin
            // drop zero-length segments and those outside the projection window
            if (len_ff == '0 || dot_ff < -DOT_W'(65536)) begin
               state_in = S_NEXT;
            end else if (exc > (DOT_W+2)'(0)) begin
               if (exc >= (DOT_W+2)'(64'd1 << EXC_W)) begin
                  state_in = S_NEXT;
               end else begin
                  exc_in   = exc[EXC_W-1:0];
                  state_in = S_SQ;
               end
            end else begin
               state_in = S_DIVGO;
            end
         end
         S_SQ: begin
            sq_in    = NUM_W'(exc_ff) * NUM_W'(exc_ff);
            state_in = S_SQCMP;
         end
         S_SQCMP: begin
            // excess beyond floor(sqrt(L<<16)) exactly when its square exceeds it
            state_in = (sq_ff > {len_ff, 16'd0}) ? S_NEXT : S_DIVGO;
         end
         S_DIVGO: begin
            state_in = S_DIVWAIT;
         end
         S_DIVWAIT: begin
            if (div_status.done) begin
               t_in     = t_wide[T_W-1:0];
               c_in     = '0;
               dist_in  = '0;
               state_in = S_PROJ;
            end
         end
         S_PROJ: begin
            if (c_ff != 2'd3) begin
               e_in = e_wide[ERR_W-1:0];
            end
            if (c_ff != 2'd0) begin
               dist_in = dist_ff + DIST_W'($unsigned(e_sq));
            end
            c_in = c_ff + 2'd1;
            if (c_ff == 2'd3) begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (!any_ff || dist_ff < best_ff) begin
               any_in      = 1'b1;
               best_in     = dist_ff;
               best_idx_in = SEG_W'(seg_ff);
            end
            state_in = S_NEXT;
         end
         S_NEXT: begin
            // advance: the far point becomes the near point
            a_in    = b_ff;
            seg_in  = seg_ff + NW'(1);
            rd_addr = AW'(seg_ff + NW'(2));
            if (seg_ff + NW'(2) < n_ff) begin
               state_in = S_LOADB;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         any_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         any_ff       <= any_in;
      end
      n_ff        <= n_in;
      seg_ff      <= seg_in;
      c_ff        <= c_in;
      q_ff        <= q_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      dv_ff       <= dv_in;
      w_ff        <= w_in;
      len_ff      <= len_in;
      dot_ff      <= dot_in;
      exc_ff      <= exc_in;
      sq_ff       <= sq_in;
      t_ff        <= t_in;
      e_ff        <= e_in;
      dist_ff     <= dist_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_item.segment_index = best_idx_ff;
   assign rsp_item.any_accepted  = any_ff;

   // a result strobe lasts one cycle
   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held");

   // a load never makes the block busy
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_item.kind == KIND_LOAD |=> !busy && !rsp_valid)
      else $error("load item started work");

   // a query always starts work
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_item.kind == KIND_QUERY |=> busy)
      else $error("query not taken");

   // the divider finishes only while waited on
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> state_ff == S_DIVWAIT)
      else $error("divider result unexpected");

endmodule

// File: rtl/nps_div.sv
module nps_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [nps_pkg::NUM_W-1:0]    num,
   input  logic [nps_pkg::LEN_W-1:0]    den,
   output logic [nps_pkg::NUM_W-1:0]    quot,
   output nps_pkg::div_status_type      status
);
   import nps_pkg::*;

   localparam int REM_W = LEN_W + 1;
   localparam int STEP_W = $clog2(NUM_W);

   logic [NUM_W-1:0]  num_ff, num_in;
   logic [NUM_W-1:0]  quot_ff, quot_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [LEN_W-1:0]  den_ff, den_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [REM_W-1:0]  rem_shift;
   logic              fits;

   always_comb begin
      num_in    = num_ff;
      quot_in   = quot_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      step_in   = step_ff;
      run_in    = run_ff;
      done_in   = 1'b0;
      rem_shift = {rem_ff[REM_W-2:0], num_ff[NUM_W-1]};
      fits      = rem_shift >= {1'b0, den_ff};
      if (start) begin
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         quot_in = '0;
         step_in = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         // one quotient bit per cycle, restoring form
         num_in  = {num_ff[NUM_W-2:0], 1'b0};
         rem_in  = fits ? rem_shift - {1'b0, den_ff} : rem_shift;
         quot_in = {quot_ff[NUM_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(NUM_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      num_ff  <= num_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign quot               = quot_ff;
   assign status.done        = done_ff;
   assign status.rem_nonzero = rem_ff != '0;

endmodule

// File: bench/tb_nearest_polyline_segment.sv
`timescale 1ns / 1ps

module tb_nearest_polyline_segment;
   import nps_pkg::*;

   localparam int NUM_POINTS  = 64;
   localparam int CYCLE_LIMIT = 4000000;
   localparam int DRAIN_WAIT  = 100;

   // Track the polyline, compute the nearest segment of each query and hold
   // the results still owed by the block.
   class segment_scoreboard;
      longint           pts[NUM_POINTS][3];
      int unsigned      count_reg;
      rsp_item_type     owed[$];
      int unsigned      mismatches;
      int unsigned      checked;

      function new();
         count_reg  = 2;
         mismatches = 0;
         checked    = 0;
      endfunction

      task report_mismatch(string what);
         $display("mismatch at %0t: %s", $time, what);
         mismatches++;
      endtask

      function void set_count(logic [31:0] value);
         count_reg = value & 32'h7F;
      endfunction

      function longint unsigned root_floor(longint unsigned v);
         longint unsigned r, bit_v;
         r = 0;
         bit_v = 64'd1 << 62;
         while (bit_v > v) bit_v >>= 2;
         while (bit_v != 0) begin
            if (v >= r + bit_v) begin
               v = v - (r + bit_v);
               r = (r >> 1) + bit_v;
            end else begin
               r >>= 1;
            end
            bit_v >>= 2;
         end
         return r;
      endfunction

      function longint div_floor(longint num, longint den);
         if (num >= 0) return num / den;
         return -(((-num) + den - 1) / den);
      endfunction

      function rsp_item_type nearest(longint q[3]);
         rsp_item_type    res;
         longint          dv[3], w[3], len, dot, t, excess, e;
         longint unsigned seg_dist, best_dist;
         int unsigned     n;
         bit              any;
         int              best;
         any = 0;
         best = 0;
         best_dist = 0;
         n = (count_reg > NUM_POINTS) ? NUM_POINTS : count_reg;
         for (int i = 0; i + 1 < n; i++) begin
            len = 0;
            dot = 0;
            for (int c = 0; c < 3; c++) begin
               dv[c] = pts[i+1][c] - pts[i][c];
               w[c]  = q[c] - pts[i][c];
               len  += dv[c] * dv[c];
               dot  += w[c] * dv[c];
            end
            // skip zero-length segments and projections outside the window
            if (len == 0) continue;
            if (dot < -65536) continue;
            excess = dot - len - 65536;
            if (excess > 0 && longint'(excess) > longint'(root_floor(len << 16))) continue;
            t = div_floor(dot * 65536, len);
            seg_dist = 0;
            for (int c = 0; c < 3; c++) begin
               e = pts[i][c] + ((dv[c] * t) >>> 16) - q[c];
               seg_dist += longint'(e * e);
            end
            if (!any || seg_dist < best_dist) begin
               any = 1;
               best_dist = seg_dist;
               best = i;
            end
         end
         res.segment_index = best[SEG_W-1:0];
         res.any_accepted  = any;
         return res;
      endfunction

      // Apply one accepted transaction: loads update the store, queries owe a result.
      function void note_transaction(req_item_type it);
         longint q[3];
         q[0] = it.coord_x;
         q[1] = it.coord_y;
         q[2] = it.coord_z;
         if (it.kind == KIND_LOAD) begin
            for (int c = 0; c < 3; c++) pts[it.point_index][c] = q[c];
         end else begin
            owed.push_back(nearest(q));
         end
      endfunction

      task check_result(rsp_item_type got);
         rsp_item_type exp_item;
         checked++;
         if (owed.size() == 0) begin
            report_mismatch("result with no query outstanding");
            return;
         end
         exp_item = owed.pop_front();
         if (got.segment_index !== exp_item.segment_index)
            report_mismatch($sformatf("segment_index got %0d want %0d",
                                      got.segment_index, exp_item.segment_index));
         if (got.any_accepted !== exp_item.any_accepted)
            report_mismatch($sformatf("any_accepted got %0b want %0b",
                                      got.any_accepted, exp_item.any_accepted));
      endtask
   endclass

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_item_type req_item;
   logic         rsp_valid;
   rsp_item_type rsp_item;
   logic         psel;
   logic         penable;
   logic         pwrite;
   logic [2:0]   paddr;
   logic [31:0]  pwdata;
   logic [31:0]  prdata;
   logic         pready;

   segment_scoreboard board;
   int unsigned       cycles;
   int unsigned       n_loads;
   int unsigned       n_queries;
   int unsigned       n_writes;
   logic [6:0]        count_now;

   nearest_polyline_segment uut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Collect every result strobe; the receiver has no way to push back.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) board.check_result(rsp_item);
   end

   // Abort a hung run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Pick a coordinate: mostly small values near the origin, sometimes full
   // range or the extremes, so every bit toggles.
   function automatic logic signed [COORD_W-1:0] pick_coord();
      int unsigned sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0:       return -20'sd524288;
         1:       return 20'sd524287;
         2, 3:    return 20'($urandom);
         default: return $signed(20'($urandom_range(0, 8191))) - 20'sd4096;
      endcase
   endfunction

   // Send one transaction: draw a gap, then hold start until busy is low at an edge.
   task automatic send_item(req_item_type it);
      int unsigned gap;
      gap = $urandom_range(0, 7);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= it;
      forever begin
         @(posedge clock);
         if (busy === 1'b0) break;
      end
      board.note_transaction(it);
      if (it.kind == KIND_LOAD) n_loads++;
      else n_queries++;
   endtask

   task automatic load_point(int idx, logic signed [COORD_W-1:0] x,
                             logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z);
      req_item_type it;
      it.kind        = KIND_LOAD;
      it.point_index = idx[5:0];
      it.coord_x     = x;
      it.coord_y     = y;
      it.coord_z     = z;
      send_item(it);
   endtask

   task automatic query_at(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                           logic signed [COORD_W-1:0] z);
      req_item_type it;
      it.kind        = KIND_QUERY;
      it.point_index = 6'($urandom);
      it.coord_x     = x;
      it.coord_y     = y;
      it.coord_z     = z;
      send_item(it);
   endtask

   // Drop start, wait out every owed result, then let the block settle.
   task automatic drain();
      start <= 1'b0;
      forever begin
         @(posedge clock);
         if (board.owed.size() == 0 && busy === 1'b0) break;
      end
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // Setup then access cycle; a read checks register 0 against the expected point count.
   task automatic csr_access(logic wr, logic [2:0] addr, logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (!wr && prdata[6:0] !== 7'(board.count_reg))
         board.report_mismatch($sformatf("point_count read %0d want %0d",
                                         prdata[6:0], board.count_reg));
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_point_count(logic [31:0] value);
      csr_access(1'b1, {REG_POINT_COUNT, 2'b00}, value);
      board.set_count(value);
      n_writes++;
      csr_access(1'b0, {REG_POINT_COUNT, 2'b00}, 32'h0);
   endtask

   // Query near a random point in use, the usual case that yields acceptances.
   task automatic query_near();
      int unsigned n, k;
      n = (board.count_reg > NUM_POINTS) ? NUM_POINTS : board.count_reg;
      if (n == 0) n = 1;
      k = $urandom_range(0, n - 1);
      query_at(20'(board.pts[k][0] + $signed($urandom_range(0, 1023)) - 512),
               20'(board.pts[k][1] + $signed($urandom_range(0, 1023)) - 512),
               20'(board.pts[k][2] + $signed($urandom_range(0, 1023)) - 512));
   endtask

   initial begin
      int unsigned phase_items;
      board     = new();
      cycles    = 0;
      n_loads   = 0;
      n_queries = 0;
      n_writes  = 0;
      reset     = 1'b1;
      start     = 1'b0;
      req_item  = '0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill the whole store first so no query ever reads an unwritten entry.
      // Points 2 and 3 coincide to give a zero-length segment; the rest walk
      // a line in x so that neighbors tie on distance.
      for (int i = 0; i < NUM_POINTS; i++) begin
         if (i == 0)      load_point(i, -20'sd524288, -20'sd524288, -20'sd524288);
         else if (i == 1) load_point(i, 20'sd524287, 20'sd524287, 20'sd524287);
         else if (i == 3) load_point(i, 20'sd512, 20'sd0, 20'sd0);
         else             load_point(i, 20'(i * 256), 20'sd0, 20'sd0);
      end

      // Reset value of two points: a single segment.
      query_at(20'sd0, 20'sd0, 20'sd0);
      query_at(-20'sd524288, 20'sd524287, -20'sd524288);
      drain();

      set_point_count(64);
      query_at(20'sd768, 20'sd0, 20'sd0);         // exactly on the segment from point 3 to point 4
      query_at(20'sd600, 20'sd100, 20'sd0);
      query_at(20'sd524287, 20'sd524287, 20'sd524287);
      query_at(-20'sd524288, -20'sd524288, -20'sd524288);
      query_at(20'sd0, -20'sd524288, 20'sd524287);
      drain();

      // Counts below two give no segments; above the store size are clamped.
      set_point_count(0);
      query_at(20'sd10, 20'sd10, 20'sd10);
      drain();
      set_point_count(1);
      query_at(20'sd10, 20'sd10, 20'sd10);
      drain();
      set_point_count(127);
      query_at(20'sd1000, 20'sd5, -20'sd5);
      drain();
      // An unmapped register address changes nothing.
      csr_access(1'b1, 3'd4, 32'd9);
      csr_access(1'b0, {REG_POINT_COUNT, 2'b00}, 32'h0);

      // Random phases: mostly short polylines, a few at full size.
      for (int ph = 0; ph < 14; ph++) begin
         if (ph == 4 || ph == 11) set_point_count(64);
         else if (ph == 7)        set_point_count(2);
         else if (ph == 9)        set_point_count($urandom_range(0, 1) ? 127 : 0);
         else                     set_point_count($urandom_range(2, 10));
         phase_items = (ph == 4 || ph == 11) ? 25 : 70;
         count_now = 7'(board.count_reg);
         for (int k = 0; k < phase_items; k++) begin
            int unsigned sel;
            sel = $urandom_range(0, 9);
            if (sel < 3)
               load_point($urandom_range(0, (count_now > 2 && count_now <= 64) ?
                                            count_now - 1 : 63),
                          pick_coord(), pick_coord(), pick_coord());
            else if (sel < 8)
               query_near();
            else
               query_at(pick_coord(), pick_coord(), pick_coord());
         end
         drain();
      end

      repeat (DRAIN_WAIT) @(posedge clock);
      if (board.owed.size() != 0)
         board.report_mismatch($sformatf("%0d results never arrived", board.owed.size()));

      $display("run: %0d loads, %0d queries, %0d point_count writes",
               n_loads, n_queries, n_writes);
      $display("checked %0d results, %0d mismatches", board.checked, board.mismatches);
      if (board.mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
